// ===== src/thc_pkg.sv =====
// Package: shared types and constants for the thermostat hysteresis controller.
`timescale 1ns / 1ps

package thc_pkg;

    // Request opcodes; the fourth code is unused and leaves the state alone
    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_UP     = 2'd1,
        OP_DOWN   = 2'd2
    } t_opcode;

    // Configuration register indexes (word address)
    typedef enum logic [1:0] {
        REG_SP_MAX = 2'd0,
        REG_SP_MIN = 2'd1,
        REG_SP_STEP = 2'd2,
        REG_HYST   = 2'd3
    } t_reg_idx;

    localparam int unsigned SP_W   = 10;
    localparam int unsigned TEMP_W = 9;
    localparam int unsigned CFG4_W = 4;
    localparam int unsigned DIG_W  = 4;

    // Reset values
    localparam logic [SP_W-1:0]   SP_RESET      = 10'd210;
    localparam logic [SP_W-1:0]   SP_MAX_RESET  = 10'd300;
    localparam logic [SP_W-1:0]   SP_MIN_RESET  = 10'd100;
    localparam logic [CFG4_W-1:0] STEP_RESET    = 4'd5;
    localparam logic [CFG4_W-1:0] HYST_RESET    = 4'd5;
    localparam logic [SP_W-1:0]   SP_LIMIT      = 10'd1023;

    // sample*80/51 == (sample * 80 * 20561) >> 20, exact for 8-bit samples
    localparam logic [28:0] SCALE_RECIP = 29'd1644880;
    localparam int unsigned SCALE_SHIFT = 20;

    // Decimal digits of the shown value
    typedef struct packed {
        logic [DIG_W-1:0] hundreds;
        logic             hundreds_blank;
        logic [DIG_W-1:0] tens;
        logic [DIG_W-1:0] units;
    } t_digits;

endpackage

// ===== src/thc_digits.sv =====
// Decimal digit split of a 10-bit display value by reciprocal multiplication.
`timescale 1ns / 1ps

module thc_digits (
    input  logic [thc_pkg::SP_W-1:0] i_value,
    output thc_pkg::t_digits         o_digits
);

    logic [15:0] w_hund_prod;
    logic [3:0]  w_hund;
    logic [9:0]  w_hund_x100;
    logic [9:0]  w_rem_full;
    logic [6:0]  w_rem;
    logic [14:0] w_tens_prod;
    logic [3:0]  w_tens;
    logic [6:0]  w_tens_x10;
    logic [6:0]  w_units_full;

    // v/100 == (v*41)>>12 for v < 1024
    always_comb begin
        w_hund_prod  = {6'd0, i_value} * 16'd41;
        w_hund       = w_hund_prod[15:12];
        w_hund_x100  = {6'd0, w_hund} * 10'd100;
        w_rem_full   = i_value - w_hund_x100;
        w_rem        = w_rem_full[6:0];
        // r/10 == (r*205)>>11 for r < 100
        w_tens_prod  = {8'd0, w_rem} * 15'd205;
        w_tens       = w_tens_prod[14:11];
        w_tens_x10   = {3'd0, w_tens} * 7'd10;
        w_units_full = w_rem - w_tens_x10;
    end

    assign o_digits.hundreds       = w_hund;
    assign o_digits.hundreds_blank = (w_hund == 4'd0);
    assign o_digits.tens           = w_tens;
    assign o_digits.units          = w_units_full[3:0];

endmodule

// ===== src/thermostat_hysteresis_controller_unit.sv =====
// Top level: on/off thermostat with hysteresis, setpoint buttons and display digits.
`timescale 1ns / 1ps
// Usage
//   Input channel (i_in_valid / o_in_ready) carries one request: an opcode
//   (sample, setpoint up, setpoint down) and an 8-bit converter sample.
//   Output channel (o_out_valid / i_out_ready) returns one result per request:
//   relay drive, scaled temperature, setpoint, change flag and display digits.
//   Pipeline: an accepted request passes the state/scaling stage (middle
//   register), then the digit stage into the output register.
//   Throughput: one request per cycle while the receiver takes results; each
//   stage loads whenever it is empty or its content moves on in the same cycle.
//   Stall: when the receiver holds i_out_ready low with a result pending, the
//   pipeline holds; o_in_ready drops only once the middle stage is also full.
//   Setpoint and relay state are updated when a request is accepted, so the
//   next request already sees them.
//   Reset (i_rst_n low, synchronous): pipeline empties, setpoint 210, relay
//   off, registers 300/100/5/5. The APB port (pready always high) holds
//   setpoint_max, setpoint_min, setpoint_step and hysteresis at 0x0..0xC;
//   write it only while the block is idle.

module thermostat_hysteresis_controller_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_opcode,
    input  logic [7:0]  i_sample,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_relay_out,
    output logic [8:0]  o_temperature,
    output logic [9:0]  o_setpoint_now,
    output logic        o_setpoint_changed,
    output logic [3:0]  o_digit_hundreds,
    output logic        o_hundreds_blank,
    output logic [3:0]  o_digit_tens,
    output logic [3:0]  o_digit_units,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // configuration and state
    logic [thc_pkg::SP_W-1:0]   r_sp_max;
    logic [thc_pkg::SP_W-1:0]   r_sp_min;
    logic [thc_pkg::CFG4_W-1:0] r_sp_step;
    logic [thc_pkg::CFG4_W-1:0] r_hyst;
    logic [thc_pkg::SP_W-1:0]   r_setpoint;
    logic [thc_pkg::SP_W-1:0]   n_setpoint;
    logic                       r_relay_on;
    logic                       n_relay_on;

    // middle stage
    logic                         r_mid_valid;
    logic                         r_mid_relay;
    logic [thc_pkg::TEMP_W-1:0]   r_mid_temp;
    logic [thc_pkg::SP_W-1:0]     r_mid_setpoint;
    logic                         r_mid_changed;
    logic [thc_pkg::SP_W-1:0]     r_mid_shown;

    // output stage
    logic                         r_out_valid;
    logic                         r_out_relay;
    logic [thc_pkg::TEMP_W-1:0]   r_out_temp;
    logic [thc_pkg::SP_W-1:0]     r_out_setpoint;
    logic                         r_out_changed;
    thc_pkg::t_digits             r_out_digits;

    logic                         w_in_acc;
    logic                         w_out_adv;
    logic                         w_mid_adv;
    logic                         w_cfg_wr;
    thc_pkg::t_reg_idx            w_reg_idx;

    logic [28:0]                  w_scale_prod;
    logic [thc_pkg::TEMP_W-1:0]   w_temp;
    logic [thc_pkg::TEMP_W-1:0]   n_temp;
    logic [10:0]                  w_t_plus_h;
    logic [10:0]                  w_sp_plus_h;
    logic [10:0]                  w_temp_wide;
    logic [10:0]                  w_sp_wide;
    logic [10:0]                  w_up_sum;
    logic [thc_pkg::SP_W-1:0]     w_step_wide;
    logic [thc_pkg::SP_W-1:0]     n_shown;
    thc_pkg::t_digits             w_digits;

    // handshake: a stage loads when it is empty or its content moves on
    assign w_out_adv  = !r_out_valid || i_out_ready;
    assign w_mid_adv  = !r_mid_valid || w_out_adv;
    assign o_in_ready = w_mid_adv;
    assign w_in_acc   = i_in_valid && w_mid_adv;

    // configuration port
    assign pready    = 1'b1;
    assign w_reg_idx = thc_pkg::t_reg_idx'(paddr[3:2]);
    assign w_cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp_max  <= thc_pkg::SP_MAX_RESET;
            r_sp_min  <= thc_pkg::SP_MIN_RESET;
            r_sp_step <= thc_pkg::STEP_RESET;
            r_hyst    <= thc_pkg::HYST_RESET;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                thc_pkg::REG_SP_MAX:  r_sp_max  <= pwdata[thc_pkg::SP_W-1:0];
                thc_pkg::REG_SP_MIN:  r_sp_min  <= pwdata[thc_pkg::SP_W-1:0];
                thc_pkg::REG_SP_STEP: r_sp_step <= pwdata[thc_pkg::CFG4_W-1:0];
                thc_pkg::REG_HYST:    r_hyst    <= pwdata[thc_pkg::CFG4_W-1:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        case (w_reg_idx)
            thc_pkg::REG_SP_MAX:  prdata = {22'd0, r_sp_max};
            thc_pkg::REG_SP_MIN:  prdata = {22'd0, r_sp_min};
            thc_pkg::REG_SP_STEP: prdata = {28'd0, r_sp_step};
            thc_pkg::REG_HYST:    prdata = {28'd0, r_hyst};
            default:              prdata = 32'd0;
        endcase
    end

    // scaling: sample*80/51 via reciprocal multiply
    assign w_scale_prod = {21'd0, i_sample} * thc_pkg::SCALE_RECIP;
    assign w_temp       = w_scale_prod[28:thc_pkg::SCALE_SHIFT];

    // widened compares, no wrap below zero
    assign w_temp_wide = {2'd0, w_temp};
    assign w_sp_wide   = {1'b0, r_setpoint};
    assign w_t_plus_h  = w_temp_wide + {7'd0, r_hyst};
    assign w_sp_plus_h = w_sp_wide + {7'd0, r_hyst};
    assign w_step_wide = {6'd0, r_sp_step};
    assign w_up_sum    = w_sp_wide + {1'b0, w_step_wide};

    // next state and shown value
    always_comb begin
        n_setpoint = r_setpoint;
        n_relay_on = r_relay_on;
        n_temp     = '0;
        n_shown    = r_setpoint;
        case (thc_pkg::t_opcode'(i_opcode))
            thc_pkg::OP_SAMPLE: begin
                n_temp  = w_temp;
                n_shown = {1'b0, w_temp};
                if (w_t_plus_h < w_sp_wide) begin
                    n_relay_on = 1'b1;
                end else if (w_temp_wide > w_sp_plus_h) begin
                    n_relay_on = 1'b0;
                end
            end
            thc_pkg::OP_UP: begin
                if (r_setpoint < r_sp_max) begin
                    n_setpoint = w_up_sum[10] ? thc_pkg::SP_LIMIT : w_up_sum[9:0];
                end
                n_shown = n_setpoint;
            end
            thc_pkg::OP_DOWN: begin
                if (r_setpoint > r_sp_min) begin
                    n_setpoint = (r_setpoint > w_step_wide) ?
                                 r_setpoint - w_step_wide : '0;
                end
                n_shown = n_setpoint;
            end
            default: ;
        endcase
    end

    // state update on request accept
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setpoint <= thc_pkg::SP_RESET;
            r_relay_on <= 1'b0;
        end else if (w_in_acc) begin
            r_setpoint <= n_setpoint;
            r_relay_on <= n_relay_on;
        end
    end

    // middle stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_valid <= 1'b0;
        end else if (w_mid_adv) begin
            r_mid_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_mid_relay    <= n_relay_on;
            r_mid_temp     <= n_temp;
            r_mid_setpoint <= n_setpoint;
            r_mid_changed  <= (n_setpoint != r_setpoint);
            r_mid_shown    <= n_shown;
        end
    end

    // digit split
    thc_digits u_digits (
        .i_value  (r_mid_shown),
        .o_digits (w_digits)
    );

    // output stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_adv) begin
            r_out_valid <= r_mid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_adv && r_mid_valid) begin
            r_out_relay    <= r_mid_relay;
            r_out_temp     <= r_mid_temp;
            r_out_setpoint <= r_mid_setpoint;
            r_out_changed  <= r_mid_changed;
            r_out_digits   <= w_digits;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_relay_out        = r_out_relay;
    assign o_temperature      = r_out_temp;
    assign o_setpoint_now     = r_out_setpoint;
    assign o_setpoint_changed = r_out_changed;
    assign o_digit_hundreds   = r_out_digits.hundreds;
    assign o_hundreds_blank   = r_out_digits.hundreds_blank;
    assign o_digit_tens       = r_out_digits.tens;
    assign o_digit_units      = r_out_digits.units;

endmodule

// ===== tb/tb_top.sv =====
// Testbench for the thermostat hysteresis controller: stimulus, result prediction and checks.
`timescale 1ns / 1ps

module tb_top;

    // Opcode 3 is not in the package enum; the block must still answer it
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int unsigned SCALE_NUM = 80;
    localparam int unsigned SCALE_DEN = 51;
    localparam int unsigned QUIET_LIMIT = 2000;
    localparam int unsigned DRAIN_CYCLES = 8;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] sample;
    } t_thermo_req;

    typedef struct packed {
        logic                       relay;
        logic [thc_pkg::TEMP_W-1:0] temp;
        logic [thc_pkg::SP_W-1:0]   sp;
        logic                       changed;
        logic [thc_pkg::DIG_W-1:0]  hundreds;
        logic                       blank;
        logic [thc_pkg::DIG_W-1:0]  tens;
        logic [thc_pkg::DIG_W-1:0]  units;
    } t_thermo_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_opcode = 2'd0;
    logic [7:0]  i_sample = 8'd0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic        o_relay_out;
    logic [8:0]  o_temperature;
    logic [9:0]  o_setpoint_now;
    logic        o_setpoint_changed;
    logic [3:0]  o_digit_hundreds;
    logic        o_hundreds_blank;
    logic [3:0]  o_digit_tens;
    logic [3:0]  o_digit_units;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = 4'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    thermostat_hysteresis_controller_unit dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_opcode           (i_opcode),
        .i_sample           (i_sample),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_relay_out        (o_relay_out),
        .o_temperature      (o_temperature),
        .o_setpoint_now     (o_setpoint_now),
        .o_setpoint_changed (o_setpoint_changed),
        .o_digit_hundreds   (o_digit_hundreds),
        .o_hundreds_blank   (o_hundreds_blank),
        .o_digit_tens       (o_digit_tens),
        .o_digit_units      (o_digit_units),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    // Shadow of the block's registers and state
    logic [thc_pkg::SP_W-1:0]   cfg_sp_max = thc_pkg::SP_MAX_RESET;
    logic [thc_pkg::SP_W-1:0]   cfg_sp_min = thc_pkg::SP_MIN_RESET;
    logic [thc_pkg::CFG4_W-1:0] cfg_step   = thc_pkg::STEP_RESET;
    logic [thc_pkg::CFG4_W-1:0] cfg_hyst   = thc_pkg::HYST_RESET;
    logic [thc_pkg::SP_W-1:0]   sp_model    = thc_pkg::SP_RESET;
    logic                       relay_model = 1'b0;

    t_thermo_req    pending_reqs[$];
    t_thermo_result expected_readings[$];
    logic           req_fire = 1'b0;
    int unsigned    reqs_taken = 0;
    int unsigned    quiet_cycles = 0;
    int unsigned    err_count = 0;

    // Clock
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Predict one result and advance the shadow state
    function automatic t_thermo_result thermostat_step(input logic [1:0] opcode,
                                                       input logic [7:0] smp);
        t_thermo_result r;
        int temp_i;
        int lo;
        int hi;
        int shown;
        int sum;
        logic [thc_pkg::SP_W-1:0] prev_sp;
        prev_sp = sp_model;
        temp_i = 0;
        case (opcode)
            thc_pkg::OP_SAMPLE: begin
                temp_i = (int'(smp) * SCALE_NUM) / SCALE_DEN;
                // signed compare, band edges may go below zero
                lo = int'(sp_model) - int'(cfg_hyst);
                hi = int'(sp_model) + int'(cfg_hyst);
                if (temp_i < lo) begin
                    relay_model = 1'b1;
                end else if (temp_i > hi) begin
                    relay_model = 1'b0;
                end
            end
            thc_pkg::OP_UP: begin
                if (sp_model < cfg_sp_max) begin
                    sum = int'(sp_model) + int'(cfg_step);
                    sp_model = (sum > int'(thc_pkg::SP_LIMIT)) ? thc_pkg::SP_LIMIT
                                                               : thc_pkg::SP_W'(sum);
                end
            end
            thc_pkg::OP_DOWN: begin
                if (sp_model > cfg_sp_min) begin
                    sp_model = (sp_model > thc_pkg::SP_W'(cfg_step)) ?
                               sp_model - thc_pkg::SP_W'(cfg_step) : '0;
                end
            end
            default: ;
        endcase
        shown = (opcode == thc_pkg::OP_SAMPLE) ? temp_i : int'(sp_model);
        r.relay    = relay_model;
        r.temp     = thc_pkg::TEMP_W'(temp_i);
        r.sp       = sp_model;
        r.changed  = (opcode != thc_pkg::OP_SAMPLE) && (sp_model != prev_sp);
        r.hundreds = thc_pkg::DIG_W'(shown / 100);
        r.blank    = (shown / 100) == 0;
        r.tens     = thc_pkg::DIG_W'((shown % 100) / 10);
        r.units    = thc_pkg::DIG_W'(shown % 10);
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endtask

    // Request driver and receiver back-pressure, both on the falling edge
    always @(negedge i_clk) begin : req_driver
        t_thermo_req nxt;
        int unsigned gap_pct;
        int unsigned stall_pct;
        if (reqs_taken < 470) begin
            gap_pct = 38;
            stall_pct = 62;
        end else if (reqs_taken < 940) begin
            gap_pct = 62;
            stall_pct = 38;
        end else begin
            gap_pct = 0;
            stall_pct = 0;
        end
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= stall_pct);
            if (!i_in_valid || req_fire) begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= gap_pct) begin
                    nxt = pending_reqs.pop_front();
                    i_in_valid <= 1'b1;
                    i_opcode <= nxt.opcode;
                    i_sample <= nxt.sample;
                end else begin
                    // junk payload while idle
                    i_in_valid <= 1'b0;
                    i_opcode <= 2'($urandom);
                    i_sample <= 8'($urandom);
                end
            end
        end
    end

    // Monitor: predict on accepted requests, check accepted results
    always @(posedge i_clk) begin : result_monitor
        t_thermo_result want;
        logic busy;
        if (!i_rst_n) begin
            req_fire <= 1'b0;
            quiet_cycles <= 0;
        end else begin
            busy = 1'b0;
            req_fire <= i_in_valid && o_in_ready;
            if (i_in_valid && o_in_ready) begin
                expected_readings.push_back(thermostat_step(i_opcode, i_sample));
                reqs_taken++;
                busy = 1'b1;
            end
            if (o_out_valid && i_out_ready) begin
                busy = 1'b1;
                if (expected_readings.size() == 0) begin
                    $error("result with no request outstanding");
                    err_count++;
                end else begin
                    want = expected_readings.pop_front();
                    check_field("relay_out", want.relay, o_relay_out);
                    check_field("temperature", want.temp, o_temperature);
                    check_field("setpoint_now", want.sp, o_setpoint_now);
                    check_field("setpoint_changed", want.changed, o_setpoint_changed);
                    check_field("digit_hundreds", want.hundreds, o_digit_hundreds);
                    check_field("hundreds_blank", want.blank, o_hundreds_blank);
                    check_field("digit_tens", want.tens, o_digit_tens);
                    check_field("digit_units", want.units, o_digit_units);
                end
            end
            quiet_cycles <= busy ? 0 : quiet_cycles + 1;
        end
    end

    // Watchdog
    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("Regression FAIL");
        $finish;
    end

    task automatic push_req(input logic [1:0] opcode, input logic [7:0] smp);
        t_thermo_req r;
        r.opcode = opcode;
        r.sample = smp;
        // keep the backlog short so generation tracks the live setpoint
        while (pending_reqs.size() >= 4) @(negedge i_clk);
        pending_reqs.push_back(r);
    endtask

    // Mostly samples, many of them around the dead band edges, plus button events and noise
    task automatic push_random(input int unsigned count);
        int unsigned pick;
        int target;
        int smp;
        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < 40) begin
                target = ($urandom_range(1) ? int'(sp_model) - int'(cfg_hyst)
                                            : int'(sp_model) + int'(cfg_hyst))
                         + int'($urandom_range(8)) - 4;
                if (target < 0) target = 0;
                smp = (target * int'(SCALE_DEN) + int'(SCALE_NUM) - 1) / int'(SCALE_NUM)
                      - int'($urandom_range(1));
                if (smp < 0) smp = 0;
                if (smp > 255) smp = 255;
                push_req(thc_pkg::OP_SAMPLE, 8'(smp));
            end else if (pick < 65) begin
                push_req(thc_pkg::OP_SAMPLE, 8'($urandom));
            end else if (pick < 80) begin
                push_req(thc_pkg::OP_UP, 8'($urandom));
            end else if (pick < 95) begin
                push_req(thc_pkg::OP_DOWN, 8'($urandom));
            end else begin
                push_req(OP_UNUSED, 8'($urandom));
            end
        end
    endtask

    // Hold off until every request is in and every result has come back
    task automatic wait_idle();
        while (pending_reqs.size() != 0 || i_in_valid || expected_readings.size() != 0)
            @(negedge i_clk);
    endtask

    // APB write with junk above the register width, then read back
    task automatic write_reg(input thc_pkg::t_reg_idx idx, input logic [31:0] val);
        int unsigned w;
        logic [31:0] masked;
        w = (idx == thc_pkg::REG_SP_MAX || idx == thc_pkg::REG_SP_MIN) ?
            thc_pkg::SP_W : thc_pkg::CFG4_W;
        masked = val & ((32'd1 << w) - 1);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= ($urandom << w) | masked;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        case (idx)
            thc_pkg::REG_SP_MAX:  cfg_sp_max = thc_pkg::SP_W'(masked);
            thc_pkg::REG_SP_MIN:  cfg_sp_min = thc_pkg::SP_W'(masked);
            thc_pkg::REG_SP_STEP: cfg_step = thc_pkg::CFG4_W'(masked);
            thc_pkg::REG_HYST:    cfg_hyst = thc_pkg::CFG4_W'(masked);
            default: ;
        endcase
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        check_field("prdata", masked, prdata);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_config(input logic [31:0] sp_max, input logic [31:0] sp_min,
                              input logic [31:0] step, input logic [31:0] hyst);
        wait_idle();
        write_reg(thc_pkg::REG_SP_MAX, sp_max);
        write_reg(thc_pkg::REG_SP_MIN, sp_min);
        write_reg(thc_pkg::REG_SP_STEP, step);
        write_reg(thc_pkg::REG_HYST, hyst);
    endtask

    // Main sequence
    initial begin : stimulus
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: sample extremes, band edges around 210 +/- 5, buttons
        push_req(thc_pkg::OP_SAMPLE, 8'd0);
        push_req(thc_pkg::OP_SAMPLE, 8'd255);
        push_req(thc_pkg::OP_SAMPLE, 8'd130);
        push_req(thc_pkg::OP_SAMPLE, 8'd131);
        push_req(thc_pkg::OP_SAMPLE, 8'd134);
        push_req(thc_pkg::OP_SAMPLE, 8'd137);
        push_req(thc_pkg::OP_SAMPLE, 8'd138);
        push_req(thc_pkg::OP_SAMPLE, 8'd131);
        push_req(thc_pkg::OP_SAMPLE, 8'd85);
        push_req(thc_pkg::OP_SAMPLE, 8'd170);
        push_req(thc_pkg::OP_UP, 8'd0);
        push_req(thc_pkg::OP_DOWN, 8'd255);
        push_req(OP_UNUSED, 8'd200);
        push_req(thc_pkg::OP_SAMPLE, 8'd64);
        push_req(OP_UNUSED, 8'd0);
        push_random(150);
        // sender pause until the pipeline has fully drained
        wait_idle();
        push_random(150);

        // Widest limits: saturate up at the top, then down to zero
        set_config(1023, 0, 15, 15);
        repeat (70) push_req(thc_pkg::OP_UP, 8'($urandom));
        push_req(thc_pkg::OP_SAMPLE, 8'd255);
        repeat (70) push_req(thc_pkg::OP_DOWN, 8'($urandom));
        push_req(thc_pkg::OP_SAMPLE, 8'd0);
        push_req(thc_pkg::OP_SAMPLE, 8'd255);
        push_req(thc_pkg::OP_SAMPLE, 8'd0);
        push_random(200);

        // Zero step and zero band
        set_config(1000, 0, 0, 0);
        push_random(150);

        // Limits that block every button event
        set_config(0, 1000, 1, 0);
        push_random(150);

        // Random settings
        repeat (3) begin
            set_config($urandom_range(1000), $urandom_range(1000),
                       $urandom_range(1, 15), $urandom_range(15));
            push_random(120);
        end

        set_config(thc_pkg::SP_MAX_RESET, thc_pkg::SP_MIN_RESET,
                   thc_pkg::STEP_RESET, thc_pkg::HYST_RESET);
        push_random(100);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
